// ===== rtl/uvs_pkg.sv =====
// shared types, constants and helper functions for the uv sphere generator
package uvs_pkg;

   localparam int CountWidth = 8;
   localparam logic [7:0] CountMask = 8'((1 << CountWidth) - 1);

   localparam logic [1:0] RegRadius  = 2'd0;
   localparam logic [1:0] RegSectors = 2'd1;
   localparam logic [1:0] RegStacks  = 2'd2;

   localparam logic [15:0] RadiusReset  = 16'd256;
   localparam logic [7:0]  SectorsReset = 8'd36;
   localparam logic [7:0]  StacksReset  = 8'd18;

   localparam int DivSteps    = 33;
   localparam int CordicSteps = 28;
   localparam int CtrlDepth   = 68;
   localparam int TexDepth    = 34;

   localparam logic [30:0]        HalfPiQ30  = 31'd1686629713;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   localparam logic signed [33:0] Q30One     = 34'sd1073741824;

   typedef struct packed {
      logic        valid;
      logic        action;
      logic        has_upper;
      logic        has_lower;
      logic [16:0] here;
      logic [17:0] below;
   } ctrl_type;

   function automatic logic signed [32:0] atan_q30(input int k);
      logic signed [32:0] a;
      case (k)
         0:       a = 33'sd843314857;
         1:       a = 33'sd497837829;
         2:       a = 33'sd263043837;
         3:       a = 33'sd133525159;
         4:       a = 33'sd67021687;
         5:       a = 33'sd33543516;
         6:       a = 33'sd16775851;
         7:       a = 33'sd8388437;
         8:       a = 33'sd4194283;
         9:       a = 33'sd2097149;
         10:      a = 33'sd1048576;
         default: a = 33'sd1 <<< (30 - k);
      endcase
      return a;
   endfunction

   // round half away from zero, then shift right by k
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int k);
      logic [63:0] m;
      logic [63:0] r;
      m = v[63] ? 64'(-v) : 64'(v);
      r = (m + (64'd1 << (k - 1))) >> k;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic [15:0] sat16(input logic [17:0] v);
      return (v > 18'd65535) ? 16'hFFFF : v[15:0];
   endfunction

endpackage

// ===== rtl/uvs_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module uvs_div (
   input  logic        clock,
   input  logic [40:0] numer,
   input  logic [8:0]  denom,
   output logic [32:0] quot
);

   logic [8:0]  rem_ff [uvs_pkg::DivSteps];
   logic [32:0] low_ff [uvs_pkg::DivSteps];
   logic [32:0] quo_ff [uvs_pkg::DivSteps];
   logic [8:0]  den_ff [uvs_pkg::DivSteps];
   logic [8:0]  rem_in [uvs_pkg::DivSteps];
   logic [32:0] low_in [uvs_pkg::DivSteps];
   logic [32:0] quo_in [uvs_pkg::DivSteps];
   logic [8:0]  den_in [uvs_pkg::DivSteps];

   for (genvar k = 0; k < uvs_pkg::DivSteps; k++) begin : g_step
      logic [8:0]  rem_prev;
      logic [8:0]  den_prev;
      logic [32:0] low_prev;
      logic [32:0] quo_prev;
      logic [9:0]  trial;
      logic        take;
      if (k == 0) begin : g_head
         assign rem_prev = {1'b0, numer[40:33]};
         assign low_prev = numer[32:0];
         assign quo_prev = '0;
         assign den_prev = denom;
      end else begin : g_tail
         assign rem_prev = rem_ff[k-1];
         assign low_prev = low_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign den_prev = den_ff[k-1];
      end
      assign trial     = {rem_prev, low_prev[32]};
      assign take      = trial >= {1'b0, den_prev};
      assign rem_in[k] = take ? 9'(trial - {1'b0, den_prev}) : trial[8:0];
      assign low_in[k] = {low_prev[31:0], 1'b0};
      assign quo_in[k] = {quo_prev[31:0], take};
      assign den_in[k] = den_prev;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < uvs_pkg::DivSteps; k++) begin
         rem_ff[k] <= rem_in[k];
         low_ff[k] <= low_in[k];
         quo_ff[k] <= quo_in[k];
         den_ff[k] <= den_in[k];
      end
   end

   assign quot = quo_ff[uvs_pkg::DivSteps-1];

endmodule

// ===== rtl/uvs_cordic.sv =====
// pipelined cordic sine and cosine of a phase in turns, q30 results
module uvs_cordic (
   input  logic               clock,
   input  logic [31:0]        phase,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);

   logic [1:0]         quad_a_ff;
   logic [60:0]        prod_a_ff;
   logic [1:0]         quad_b_ff;
   logic signed [32:0] z_b_ff;
   logic signed [33:0] x_ff [uvs_pkg::CordicSteps];
   logic signed [33:0] y_ff [uvs_pkg::CordicSteps];
   logic signed [32:0] z_ff [uvs_pkg::CordicSteps];
   logic [1:0]         q_ff [uvs_pkg::CordicSteps];
   logic signed [33:0] x_in [uvs_pkg::CordicSteps];
   logic signed [33:0] y_in [uvs_pkg::CordicSteps];
   logic signed [32:0] z_in [uvs_pkg::CordicSteps];
   logic [1:0]         q_in [uvs_pkg::CordicSteps];
   logic [61:0]        z_sum;
   logic signed [33:0] xc;
   logic signed [33:0] yc;
   logic signed [31:0] cos_ff;
   logic signed [31:0] sin_ff;

   assign z_sum = 62'(prod_a_ff) + (62'd1 << 29);

   always_ff @(posedge clock) begin
      quad_a_ff <= phase[31:30];
      prod_a_ff <= 61'(phase[29:0]) * 61'(uvs_pkg::HalfPiQ30);
      quad_b_ff <= quad_a_ff;
      z_b_ff    <= $signed({2'b00, z_sum[60:30]});
   end

   for (genvar k = 0; k < uvs_pkg::CordicSteps; k++) begin : g_iter
      logic signed [33:0] xp;
      logic signed [33:0] yp;
      logic signed [32:0] zp;
      logic [1:0]         qp;
      if (k == 0) begin : g_head
         assign xp = uvs_pkg::CordicGain;
         assign yp = '0;
         assign zp = z_b_ff;
         assign qp = quad_b_ff;
      end else begin : g_tail
         assign xp = x_ff[k-1];
         assign yp = y_ff[k-1];
         assign zp = z_ff[k-1];
         assign qp = q_ff[k-1];
      end
      assign x_in[k] = zp[32] ? xp + (yp >>> k) : xp - (yp >>> k);
      assign y_in[k] = zp[32] ? yp - (xp >>> k) : yp + (xp >>> k);
      assign z_in[k] = zp[32] ? zp + uvs_pkg::atan_q30(k) : zp - uvs_pkg::atan_q30(k);
      assign q_in[k] = qp;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < uvs_pkg::CordicSteps; k++) begin
         x_ff[k] <= x_in[k];
         y_ff[k] <= y_in[k];
         z_ff[k] <= z_in[k];
         q_ff[k] <= q_in[k];
      end
   end

   always_comb begin
      xc = x_ff[uvs_pkg::CordicSteps-1];
      yc = y_ff[uvs_pkg::CordicSteps-1];
      if (xc[33]) begin
         xc = '0;
      end else if (xc > uvs_pkg::Q30One) begin
         xc = uvs_pkg::Q30One;
      end
      if (yc[33]) begin
         yc = '0;
      end else if (yc > uvs_pkg::Q30One) begin
         yc = uvs_pkg::Q30One;
      end
   end

   always_ff @(posedge clock) begin
      case (q_ff[uvs_pkg::CordicSteps-1])
         2'd0: begin
            cos_ff <= 32'(xc);
            sin_ff <= 32'(yc);
         end
         2'd1: begin
            cos_ff <= 32'(-yc);
            sin_ff <= 32'(xc);
         end
         2'd2: begin
            cos_ff <= 32'(-xc);
            sin_ff <= 32'(-yc);
         end
         default: begin
            cos_ff <= 32'(yc);
            sin_ff <= 32'(-xc);
         end
      endcase
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ===== rtl/uv_sphere_vertex_and_triangle_gen.sv =====
// top level of the uv sphere vertex and triangle generator
// results appear in request order
// one request per cycle while busy is low: divider and cordic pipelines take a new request every cycle
// a cell request with two triangles raises busy for the following cycle
// reset restores radius 256, sectors 36, stacks 18 and empties the pipeline
module uv_sphere_vertex_and_triangle_gen (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [7:0]         req_stack_index,
   input  logic [7:0]         req_sector_index,
   output logic               rsp_valid,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [15:0]        rsp_corner_a,
   output logic [15:0]        rsp_corner_b,
   output logic [15:0]        rsp_corner_c,
   output logic               rsp_final_res,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [15:0] radius_ff;
   logic [7:0]  sectors_ff;
   logic [7:0]  stacks_ff;
   logic        busy_ff;
   logic        busy_in;
   logic        accept;
   logic        csr_write;

   logic [7:0]  nsec;
   logic [7:0]  nst;
   logic [7:0]  iv;
   logic [7:0]  jv;
   logic [7:0]  ic;
   logic [7:0]  jc;
   logic [8:0]  row;
   logic [16:0] here_in;
   logic [17:0] below_in;
   uvs_pkg::ctrl_type ctrl_in;
   uvs_pkg::ctrl_type ctrl_ff [uvs_pkg::CtrlDepth];

   logic [40:0] num_pa_ff, num_pb_ff, num_tu_ff, num_tv_ff;
   logic [8:0]  den_pa_ff, den_pb_ff, den_tu_ff, den_tv_ff;
   logic [32:0] pa_q, pb_q, tu_q, tv_q;
   logic [16:0] tu_ff [uvs_pkg::TexDepth];
   logic [16:0] tv_ff [uvs_pkg::TexDepth];

   logic signed [31:0] ca, sa, cb, sb;
   logic signed [63:0] p1_cb_ff, p1_sb_ff;
   logic signed [31:0] p1_ca_ff;
   logic signed [31:0] t_ff [3];
   logic signed [48:0] pm_ff [3];
   logic [15:0]        nrm_ff [3];
   logic signed [63:0] rnd_cb, rnd_sb;
   logic signed [63:0] rnd_pos [3];
   logic signed [63:0] rnd_nrm [3];

   logic               out_valid_ff;
   logic signed [16:0] pos_ff [3];
   logic signed [15:0] norm_ff [3];
   logic [16:0]        tex_u_ff, tex_v_ff;
   logic [15:0]        corner_a_ff, corner_b_ff, corner_c_ff;
   logic               final_ff;
   logic               pend_ff;
   logic [16:0]        pend_here_ff;
   logic [17:0]        pend_below_ff;
   uvs_pkg::ctrl_type  tail;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= uvs_pkg::RadiusReset;
         sectors_ff <= uvs_pkg::SectorsReset;
         stacks_ff  <= uvs_pkg::StacksReset;
      end else if (csr_write) begin
         case (paddr[3:2])
            uvs_pkg::RegRadius:  radius_ff  <= pwdata[15:0];
            uvs_pkg::RegSectors: sectors_ff <= pwdata[7:0] & uvs_pkg::CountMask;
            uvs_pkg::RegStacks:  stacks_ff  <= pwdata[7:0] & uvs_pkg::CountMask;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         uvs_pkg::RegRadius:  prdata = {16'd0, radius_ff};
         uvs_pkg::RegSectors: prdata = {24'd0, sectors_ff};
         uvs_pkg::RegStacks:  prdata = {24'd0, stacks_ff};
         default:             prdata = '0;
      endcase
   end

   // request decode
   assign accept   = start && !busy_ff;
   assign nsec     = (sectors_ff < 8'd3) ? 8'd3 : sectors_ff;
   assign nst      = (stacks_ff < 8'd2) ? 8'd2 : stacks_ff;
   assign iv       = (req_stack_index > nst) ? nst : req_stack_index;
   assign jv       = (req_sector_index > nsec) ? nsec : req_sector_index;
   assign ic       = (req_stack_index > nst - 8'd1) ? nst - 8'd1 : req_stack_index;
   assign jc       = (req_sector_index > nsec - 8'd1) ? nsec - 8'd1 : req_sector_index;
   assign row      = {1'b0, nsec} + 9'd1;
   assign here_in  = 17'(ic) * 17'(row) + 17'(jc);
   assign below_in = 18'(here_in) + 18'(row);

   always_comb begin
      ctrl_in.valid     = accept;
      ctrl_in.action    = req_action;
      ctrl_in.has_upper = ic != 8'd0;
      ctrl_in.has_lower = ic != nst - 8'd1;
      ctrl_in.here      = here_in;
      ctrl_in.below     = below_in;
   end

   assign busy_in = accept && req_action && ctrl_in.has_upper && ctrl_in.has_lower;
   assign busy    = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < uvs_pkg::CtrlDepth; k++) begin
            ctrl_ff[k].valid <= 1'b0;
         end
      end else begin
         ctrl_ff[0] <= ctrl_in;
         for (int k = 1; k < uvs_pkg::CtrlDepth; k++) begin
            ctrl_ff[k] <= ctrl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      num_pa_ff <= {1'b0, iv, 32'd0} + 41'(nst);
      den_pa_ff <= {nst, 1'b0};
      num_pb_ff <= {1'b0, jv, 32'd0} + 41'(nsec >> 1);
      den_pb_ff <= {1'b0, nsec};
      num_tu_ff <= 41'({jv, 16'd0}) + 41'(nsec >> 1);
      den_tu_ff <= {1'b0, nsec};
      num_tv_ff <= 41'({iv, 16'd0}) + 41'(nst >> 1);
      den_tv_ff <= {1'b0, nst};
   end

   uvs_div u_div_pa (.clock(clock), .numer(num_pa_ff), .denom(den_pa_ff), .quot(pa_q));
   uvs_div u_div_pb (.clock(clock), .numer(num_pb_ff), .denom(den_pb_ff), .quot(pb_q));
   uvs_div u_div_tu (.clock(clock), .numer(num_tu_ff), .denom(den_tu_ff), .quot(tu_q));
   uvs_div u_div_tv (.clock(clock), .numer(num_tv_ff), .denom(den_tv_ff), .quot(tv_q));

   always_ff @(posedge clock) begin
      tu_ff[0] <= tu_q[16:0];
      tv_ff[0] <= tv_q[16:0];
      for (int k = 1; k < uvs_pkg::TexDepth; k++) begin
         tu_ff[k] <= tu_ff[k-1];
         tv_ff[k] <= tv_ff[k-1];
      end
   end

   uvs_cordic u_cordic_a (.clock(clock), .phase(pa_q[31:0]), .cos_out(ca), .sin_out(sa));
   uvs_cordic u_cordic_b (.clock(clock), .phase(pb_q[31:0]), .cos_out(cb), .sin_out(sb));

   // direction products, rounding, radius scaling
   assign rnd_cb = uvs_pkg::round_shift(p1_cb_ff, 30);
   assign rnd_sb = uvs_pkg::round_shift(p1_sb_ff, 30);

   for (genvar d = 0; d < 3; d++) begin : g_axis
      assign rnd_nrm[d] = uvs_pkg::round_shift(64'(t_ff[d]), 16);
      assign rnd_pos[d] = uvs_pkg::round_shift(64'(pm_ff[d]), 30);
   end

   always_ff @(posedge clock) begin
      p1_cb_ff <= sa * cb;
      p1_sb_ff <= sa * sb;
      p1_ca_ff <= ca;
      t_ff[0]  <= rnd_cb[31:0];
      t_ff[1]  <= rnd_sb[31:0];
      t_ff[2]  <= p1_ca_ff;
      for (int d = 0; d < 3; d++) begin
         pm_ff[d]  <= $signed({1'b0, radius_ff}) * t_ff[d];
         nrm_ff[d] <= rnd_nrm[d][15:0];
      end
   end

   // result register and second triangle slot
   assign tail = ctrl_ff[uvs_pkg::CtrlDepth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= tail.valid || pend_ff;
         pend_ff      <= tail.valid && tail.action && tail.has_upper && tail.has_lower;
      end
   end

   always_ff @(posedge clock) begin
      if (tail.valid) begin
         pend_here_ff  <= tail.here;
         pend_below_ff <= tail.below;
         if (!tail.action) begin
            for (int d = 0; d < 3; d++) begin
               pos_ff[d]  <= rnd_pos[d][16:0];
               norm_ff[d] <= nrm_ff[d];
            end
            tex_u_ff    <= tu_ff[uvs_pkg::TexDepth-1];
            tex_v_ff    <= tv_ff[uvs_pkg::TexDepth-1];
            corner_a_ff <= '0;
            corner_b_ff <= '0;
            corner_c_ff <= '0;
            final_ff    <= 1'b1;
         end else begin
            for (int d = 0; d < 3; d++) begin
               pos_ff[d]  <= '0;
               norm_ff[d] <= '0;
            end
            tex_u_ff <= '0;
            tex_v_ff <= '0;
            if (tail.has_upper) begin
               corner_a_ff <= uvs_pkg::sat16(18'(tail.here));
               corner_b_ff <= uvs_pkg::sat16(tail.below);
               corner_c_ff <= uvs_pkg::sat16(18'(tail.here) + 18'd1);
               final_ff    <= !tail.has_lower;
            end else begin
               corner_a_ff <= uvs_pkg::sat16(18'(tail.here) + 18'd1);
               corner_b_ff <= uvs_pkg::sat16(tail.below);
               corner_c_ff <= uvs_pkg::sat16(tail.below + 18'd1);
               final_ff    <= 1'b1;
            end
         end
      end else if (pend_ff) begin
         corner_a_ff <= uvs_pkg::sat16(18'(pend_here_ff) + 18'd1);
         corner_b_ff <= uvs_pkg::sat16(pend_below_ff);
         corner_c_ff <= uvs_pkg::sat16(pend_below_ff + 18'd1);
         final_ff    <= 1'b1;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pos_x     = pos_ff[0];
   assign rsp_pos_y     = pos_ff[1];
   assign rsp_pos_z     = pos_ff[2];
   assign rsp_norm_x    = norm_ff[0];
   assign rsp_norm_y    = norm_ff[1];
   assign rsp_norm_z    = norm_ff[2];
   assign rsp_tex_u     = tex_u_ff;
   assign rsp_tex_v     = tex_v_ff;
   assign rsp_corner_a  = corner_a_ff;
   assign rsp_corner_b  = corner_b_ff;
   assign rsp_corner_c  = corner_c_ff;
   assign rsp_final_res = final_ff;

endmodule

// ===== test/uv_sphere_vertex_and_triangle_gen_tb.sv =====
// self-checking testbench for the uv sphere vertex and triangle generator
module uv_sphere_vertex_and_triangle_gen_tb;

   typedef struct {
      logic [16:0] pos_x, pos_y, pos_z;
      logic [15:0] norm_x, norm_y, norm_z;
      logic [16:0] tex_u, tex_v;
      logic [15:0] corner_a, corner_b, corner_c;
      logic        final_res;
   } mesh_result_type;

   class mesh_scoreboard_type;
      mesh_result_type pending[$];
      logic [15:0] radius = uvs_pkg::RadiusReset;
      logic [7:0] sectors = uvs_pkg::SectorsReset;
      logic [7:0] stacks = uvs_pkg::StacksReset;
      int errors = 0;
      int results = 0;

      function automatic longint unsigned num_sectors();
         return (sectors < 3) ? 3 : sectors;
      endfunction

      function automatic longint unsigned num_stacks();
         return (stacks < 2) ? 2 : stacks;
      endfunction

      function automatic longint round_off(longint v, int k);
         longint unsigned m;
         m = (v < 0) ? -v : v;
         m = (m + (64'd1 << (k - 1))) >> k;
         return (v < 0) ? -longint'(m) : longint'(m);
      endfunction

      function automatic void turn_to_trig(logic [31:0] phase, output longint cs,
                                           output longint sn);
         longint unsigned prod;
         longint x, y, z, ang, dx, dy;
         prod = longint'(phase[29:0]) * longint'(uvs_pkg::HalfPiQ30);
         z = (prod + (64'd1 << 29)) >> 30;
         x = uvs_pkg::CordicGain;
         y = 0;
         for (int k = 0; k < uvs_pkg::CordicSteps; k++) begin
            case (k)
               0: ang = 843314857;
               1: ang = 497837829;
               2: ang = 263043837;
               3: ang = 133525159;
               4: ang = 67021687;
               5: ang = 33543516;
               6: ang = 16775851;
               7: ang = 8388437;
               8: ang = 4194283;
               9: ang = 2097149;
               10: ang = 1048576;
               default: ang = longint'(1) << (30 - k);
            endcase
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ang;
            end else begin
               x += dx; y -= dy; z += ang;
            end
         end
         if (x < 0) x = 0;
         if (x > uvs_pkg::Q30One) x = uvs_pkg::Q30One;
         if (y < 0) y = 0;
         if (y > uvs_pkg::Q30One) y = uvs_pkg::Q30One;
         case (phase[31:30])
            2'd0: begin cs = x; sn = y; end
            2'd1: begin cs = -y; sn = x; end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
         endcase
      endfunction

      function automatic void push_triangle(longint unsigned a, longint unsigned b,
                                            longint unsigned c);
         mesh_result_type r;
         r = '{default: '0};
         r.corner_a = (a > 65535) ? 16'hFFFF : a[15:0];
         r.corner_b = (b > 65535) ? 16'hFFFF : b[15:0];
         r.corner_c = (c > 65535) ? 16'hFFFF : c[15:0];
         pending.push_back(r);
      endfunction

      function automatic void note_request(logic act, logic [7:0] si, logic [7:0] sj);
         longint unsigned ns, nt, i, j, here, below;
         logic [63:0] num;
         logic [31:0] pa, pb;
         longint ca, sa, cb, sb;
         longint t[3];
         longint p;
         mesh_result_type r;
         ns = num_sectors();
         nt = num_stacks();
         if (!act) begin
            i = (si > nt) ? nt : si;
            j = (sj > ns) ? ns : sj;
            num = (i << 32) + nt;
            num = num / (2 * nt);
            pa = num[31:0];
            num = (j << 32) + ns / 2;
            num = num / ns;
            pb = num[31:0];
            turn_to_trig(pa, ca, sa);
            turn_to_trig(pb, cb, sb);
            t[0] = round_off(sa * cb, 30);
            t[1] = round_off(sa * sb, 30);
            t[2] = ca;
            r = '{default: '0};
            p = round_off(longint'(radius) * t[0], 30); r.pos_x = p[16:0];
            p = round_off(longint'(radius) * t[1], 30); r.pos_y = p[16:0];
            p = round_off(longint'(radius) * t[2], 30); r.pos_z = p[16:0];
            p = round_off(t[0], 16); r.norm_x = p[15:0];
            p = round_off(t[1], 16); r.norm_y = p[15:0];
            p = round_off(t[2], 16); r.norm_z = p[15:0];
            num = (j * 65536 + ns / 2) / ns; r.tex_u = num[16:0];
            num = (i * 65536 + nt / 2) / nt; r.tex_v = num[16:0];
            r.final_res = 1'b1;
            pending.push_back(r);
         end else begin
            i = (si > nt - 1) ? nt - 1 : si;
            j = (sj > ns - 1) ? ns - 1 : sj;
            here = i * (ns + 1) + j;
            below = here + ns + 1;
            if (i != 0) push_triangle(here, below, here + 1);
            if (i != nt - 1) push_triangle(here + 1, below, below + 1);
            pending[$].final_res = 1'b1;
         end
      endfunction

      function automatic void compare_field(string name, logic [16:0] want,
                                            logic [16:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function automatic void check_result(mesh_result_type got);
         mesh_result_type want;
         results++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual corners %0d %0d %0d",
                     $time, got.corner_a, got.corner_b, got.corner_c);
            return;
         end
         want = pending.pop_front();
         compare_field("pos_x", want.pos_x, got.pos_x);
         compare_field("pos_y", want.pos_y, got.pos_y);
         compare_field("pos_z", want.pos_z, got.pos_z);
         compare_field("norm_x", want.norm_x, got.norm_x);
         compare_field("norm_y", want.norm_y, got.norm_y);
         compare_field("norm_z", want.norm_z, got.norm_z);
         compare_field("tex_u", want.tex_u, got.tex_u);
         compare_field("tex_v", want.tex_v, got.tex_v);
         compare_field("corner_a", want.corner_a, got.corner_a);
         compare_field("corner_b", want.corner_b, got.corner_b);
         compare_field("corner_c", want.corner_c, got.corner_c);
         compare_field("final_res", want.final_res, got.final_res);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = 1'b0;
   logic [7:0] req_stack_index = '0;
   logic [7:0] req_sector_index = '0;
   logic rsp_valid;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic [16:0] rsp_tex_u, rsp_tex_v;
   logic [15:0] rsp_corner_a, rsp_corner_b, rsp_corner_c;
   logic rsp_final_res;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   mesh_scoreboard_type board = new();
   int cycles = 0;
   int vertex_requests = 0;
   int cell_requests = 0;
   int settings_used = 0;
   bit calm = 0;

   uv_sphere_vertex_and_triangle_gen uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      mesh_result_type got;
      if (!reset && rsp_valid) begin
         got.pos_x = rsp_pos_x; got.pos_y = rsp_pos_y; got.pos_z = rsp_pos_z;
         got.norm_x = rsp_norm_x; got.norm_y = rsp_norm_y; got.norm_z = rsp_norm_z;
         got.tex_u = rsp_tex_u; got.tex_v = rsp_tex_v;
         got.corner_a = rsp_corner_a; got.corner_b = rsp_corner_b;
         got.corner_c = rsp_corner_c; got.final_res = rsp_final_res;
         board.check_result(got);
      end
   end

   task automatic send_request(logic act, logic [7:0] si, logic [7:0] sj);
      req_action <= act;
      req_stack_index <= si;
      req_sector_index <= sj;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      board.note_request(act, si, sj);
      if (act) cell_requests++; else vertex_requests++;
      if (!calm && $urandom_range(3, 0) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(17, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         uvs_pkg::RegRadius: board.radius = data[15:0];
         uvs_pkg::RegSectors: board.sectors = data[7:0] & uvs_pkg::CountMask;
         default: board.stacks = data[7:0] & uvs_pkg::CountMask;
      endcase
   endtask

   task automatic apply_setting(logic [15:0] rad, logic [7:0] sec, logic [7:0] stk);
      drain();
      write_reg(uvs_pkg::RegRadius, {16'($urandom_range(65535, 0)), rad});
      write_reg(uvs_pkg::RegSectors,
                {16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)), sec});
      write_reg(uvs_pkg::RegStacks,
                {16'($urandom_range(65535, 0)), 8'($urandom_range(255, 0)), stk});
      settings_used++;
   endtask

   task automatic random_requests(int count);
      logic [7:0] si, sj;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9, 0) < 7) begin
            si = 8'($urandom_range(32'(board.num_stacks() + 1), 0));
            sj = 8'($urandom_range(32'(board.num_sectors() + 1), 0));
         end else begin
            si = 8'($urandom_range(255, 0));
            sj = 8'($urandom_range(255, 0));
         end
         send_request(1'($urandom_range(1, 0)), si, sj);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(1'b0, 8'd0, 8'd0);
      send_request(1'b0, 8'd18, 8'd36);
      send_request(1'b0, 8'd9, 8'd9);
      send_request(1'b0, 8'd255, 8'd255);
      send_request(1'b0, 8'd5, 8'd27);
      send_request(1'b1, 8'd0, 8'd0);
      send_request(1'b1, 8'd17, 8'd35);
      send_request(1'b1, 8'd8, 8'd10);
      send_request(1'b1, 8'd255, 8'd255);
      send_request(1'b1, 8'd0, 8'd255);
      random_requests(100);
      apply_setting(16'hFFFF, 8'd255, 8'd255);
      send_request(1'b0, 8'd255, 8'd255);
      send_request(1'b0, 8'd128, 8'd64);
      send_request(1'b1, 8'd254, 8'd254);
      send_request(1'b1, 8'd0, 8'd254);
      send_request(1'b1, 8'd170, 8'd85);
      random_requests(120);
      apply_setting(16'd0, 8'd3, 8'd2);
      send_request(1'b0, 8'd1, 8'd2);
      send_request(1'b1, 8'd0, 8'd2);
      send_request(1'b1, 8'd1, 8'd0);
      random_requests(120);
      apply_setting(16'd1000, 8'd0, 8'd1);
      random_requests(110);
      apply_setting(16'd383, 8'd2, 8'd0);
      random_requests(110);
      apply_setting(16'($urandom_range(65535, 0)), 8'($urandom_range(255, 3)),
                    8'($urandom_range(255, 2)));
      random_requests(110);
      calm = 1;
      apply_setting(16'($urandom_range(65535, 0)), 8'($urandom_range(40, 3)),
                    8'($urandom_range(40, 2)));
      random_requests(110);
      drain();
      if (board.pending.size() != 0) begin
         board.errors++;
         $display("%0t: %0d results never arrived", $time, board.pending.size());
      end
      $display("covered %0d vertex and %0d cell requests over %0d register settings",
               vertex_requests, cell_requests, settings_used + 1);
      $display("checked %0d results, %0d field mismatches", board.results, board.errors);
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== uv_sphere_vertex_and_triangle_gen.f =====
rtl/uvs_pkg.sv
rtl/uvs_div.sv
rtl/uvs_cordic.sv
rtl/uv_sphere_vertex_and_triangle_gen.sv
test/uv_sphere_vertex_and_triangle_gen_tb.sv
